/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define CHECK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence, by a non-overlapping implication.
`define CHECK_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* design/hsv2rgb_pkg.sv */
// Package: widths, fixed-point constants and sector codes of the converter.
package hsv2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FW        = FRAC_BITS + 1;   // width of a fraction that can hold 1.0
    localparam int PW        = 2 * FW;          // width of a full fraction product
    localparam int HW        = FRAC_BITS + 3;   // width of hue times six
    localparam int BW        = FW + 8;          // width of a component times 255

    localparam logic [FW-1:0] ONE_Q    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [HW-1:0] HUE_MUL  = HW'(6);
    localparam logic [BW-1:0] BYTE_MUL = BW'(255);

    // Hue sectors, named after the two colors each one spans.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

endpackage

/* design/hsv_to_rgb_converter_core.sv */
// HSV to RGB converter: four register stages, one pixel word accepted per cycle while hsv_stall is low.
// Path: an accepted word passes through stage 1, stage 2, stage 3 and the output register.
// Throughput: one word per cycle while nothing stalls; each stage has its own valid bit, so bubbles collapse
// and the input keeps taking words while a finished word waits at the output, until every stage is full.
// Reset: rst_n clears all valid bits at once; payload registers are not reset.
`include "assert_macros.svh"

module hsv_to_rgb_converter_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        hsv_valid,
    output logic                        hsv_stall,
    input  logic [hsv2rgb_pkg::FW-1:0]  hue,
    input  logic [hsv2rgb_pkg::FW-1:0]  saturation,
    input  logic [hsv2rgb_pkg::FW-1:0]  brightness,
    output logic                        rgb_valid,
    input  logic                        rgb_stall,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue
);
    import hsv2rgb_pkg::*;

    // Stage 1: wrap hue, clamp s and v, scale hue by six, split into sector and fraction.
    logic                 s1_valid_reg;
    sector_t              s1_sector_reg, s1_sector_next;
    logic [FRAC_BITS-1:0] s1_frac_reg, s1_frac_next;
    logic [FW-1:0]        s1_sat_reg, s1_sat_next;
    logic [FW-1:0]        s1_val_reg, s1_val_next;
    logic [HW-1:0]        hue6;

    // Stage 2: s*f, s*(1-f) and p = v*(1-s).
    logic                 s2_valid_reg;
    sector_t              s2_sector_reg;
    logic [FW-1:0]        s2_sf_reg, s2_sf_next;
    logic [FW-1:0]        s2_sfc_reg, s2_sfc_next;
    logic [FW-1:0]        s2_p_reg, s2_p_next;
    logic [FW-1:0]        s2_val_reg;
    logic [PW-1:0]        sf_prod, sfc_prod, p_prod;

    // Stage 3: q = v*(1-sf) and t = v*(1-s(1-f)).
    logic                 s3_valid_reg;
    sector_t              s3_sector_reg;
    logic [FW-1:0]        s3_q_reg, s3_q_next;
    logic [FW-1:0]        s3_t_reg, s3_t_next;
    logic [FW-1:0]        s3_p_reg;
    logic [FW-1:0]        s3_val_reg;
    logic [PW-1:0]        q_prod, t_prod;

    // Stage 4: pick the sector's triple and scale each component to a byte.
    logic                 out_valid_reg;
    logic [7:0]           red_reg, red_next;
    logic [7:0]           green_reg, green_next;
    logic [7:0]           blue_reg, blue_next;
    logic [FW-1:0]        r_sel, g_sel, b_sel;
    logic [BW-1:0]        r_prod, g_prod, b_prod;

    // Each stage advances when it is empty or the one after it advances.
    logic out_ready, s3_ready, s2_ready, s1_ready;

    assign out_ready = !out_valid_reg || !rgb_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign hsv_stall = !s1_ready;

    // Stage 1 logic: a hue of one or more wraps to zero; s and v clamp to one.
    always_comb
    begin
        logic [FW-1:0] hue_w;
        hue_w       = (hue >= ONE_Q) ? '0 : hue;
        hue6        = HW'(hue_w) * HUE_MUL;
        s1_sector_next = sector_t'(hue6[HW-1:FRAC_BITS]);
        s1_frac_next   = hue6[FRAC_BITS-1:0];
        s1_sat_next    = (saturation > ONE_Q) ? ONE_Q : saturation;
        s1_val_next    = (brightness > ONE_Q) ? ONE_Q : brightness;
    end

    // Stage 2 logic: three independent products, each truncated.
    always_comb
    begin
        sf_prod     = PW'(s1_sat_reg) * PW'({1'b0, s1_frac_reg});
        sfc_prod    = PW'(s1_sat_reg) * PW'(ONE_Q - FW'({1'b0, s1_frac_reg}));
        p_prod      = PW'(s1_val_reg) * PW'(ONE_Q - s1_sat_reg);
        s2_sf_next  = sf_prod[FRAC_BITS +: FW];
        s2_sfc_next = sfc_prod[FRAC_BITS +: FW];
        s2_p_next   = p_prod[FRAC_BITS +: FW];
    end

    // Stage 3 logic: both terms stay at or below s, so 1 - term never wraps.
    always_comb
    begin
        q_prod    = PW'(s2_val_reg) * PW'(ONE_Q - s2_sf_reg);
        t_prod    = PW'(s2_val_reg) * PW'(ONE_Q - s2_sfc_reg);
        s3_q_next = q_prod[FRAC_BITS +: FW];
        s3_t_next = t_prod[FRAC_BITS +: FW];
    end

    // Stage 4 logic: sector select, then times 255 and drop the fraction.
    always_comb
    begin
        case (s3_sector_reg)
            SEC_RED_YEL:
            begin
                r_sel = s3_val_reg; g_sel = s3_t_reg;   b_sel = s3_p_reg;
            end
            SEC_YEL_GRN:
            begin
                r_sel = s3_q_reg;   g_sel = s3_val_reg; b_sel = s3_p_reg;
            end
            SEC_GRN_CYN:
            begin
                r_sel = s3_p_reg;   g_sel = s3_val_reg; b_sel = s3_t_reg;
            end
            SEC_CYN_BLU:
            begin
                r_sel = s3_p_reg;   g_sel = s3_q_reg;   b_sel = s3_val_reg;
            end
            SEC_BLU_MAG:
            begin
                r_sel = s3_t_reg;   g_sel = s3_p_reg;   b_sel = s3_val_reg;
            end
            default:
            begin
                r_sel = s3_val_reg; g_sel = s3_p_reg;   b_sel = s3_q_reg;
            end
        endcase
        r_prod     = BW'(r_sel) * BYTE_MUL;
        g_prod     = BW'(g_sel) * BYTE_MUL;
        b_prod     = BW'(b_sel) * BYTE_MUL;
        red_next   = r_prod[FRAC_BITS +: 8];
        green_next = g_prod[FRAC_BITS +: 8];
        blue_next  = b_prod[FRAC_BITS +: 8];
    end

    // Valid bits: advance on ready, hold otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= hsv_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload: load with the stage's ready, no reset.
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_sector_reg <= s1_sector_next;
            s1_frac_reg   <= s1_frac_next;
            s1_sat_reg    <= s1_sat_next;
            s1_val_reg    <= s1_val_next;
        end
        if (s2_ready)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_sf_reg     <= s2_sf_next;
            s2_sfc_reg    <= s2_sfc_next;
            s2_p_reg      <= s2_p_next;
            s2_val_reg    <= s1_val_reg;
        end
        if (s3_ready)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_q_reg      <= s3_q_next;
            s3_t_reg      <= s3_t_next;
            s3_p_reg      <= s2_p_reg;
            s3_val_reg    <= s2_val_reg;
        end
        if (out_ready)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // An accepted word always lands in the first stage.
    `CHECK_NEXT(a_accept_lands, hsv_valid && !hsv_stall, s1_valid_reg, "accepted word lost")
    // A full pipeline behind a stalled output must stall the input.
    `CHECK_ALWAYS(a_full_stalls, !(rgb_valid && rgb_stall && s1_valid_reg && s2_valid_reg && s3_valid_reg) || hsv_stall, "input taken while pipeline full")
    // A word waiting behind a stalled output stays in stage 3.
    `CHECK_NEXT(a_s3_holds, s3_valid_reg && rgb_valid && rgb_stall, s3_valid_reg, "stage 3 word dropped")

endmodule
